>>> sv/rpaf_pkg.sv
package rpaf_pkg;

  localparam int DEFAULT_FIFO_DEPTH = 256;
  localparam int HEADER_BYTES       = 4;
  localparam int CFG_INDEX_W        = 8;
  localparam int OUT_DATA_W         = 56;

  localparam logic [CFG_INDEX_W-1:0] CFG_NODE_ADDR  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_BCAST_ADDR = CFG_INDEX_W'(1);

  localparam logic [7:0] NODE_ADDR_RESET  = 8'h00;
  localparam logic [7:0] BCAST_ADDR_RESET = 8'hFF;

  typedef enum logic {
    OP_RX_BYTE = 1'b0,
    OP_POP     = 1'b1
  } op_e;

  typedef struct packed {
    logic [7:0] src;
    logic [7:0] ident;
    logic [7:0] flags;
  } hdr_t;

  typedef struct packed {
    logic       pop_valid;
    logic       overflow;
    logic       head_valid;
    logic [7:0] fill;
    logic [7:0] pop_byte;
    logic [7:0] head_byte;
  } ring_st_t;

endpackage

>>> sv/rx_packet_address_filter_fifo_core.sv
// order: an accepted input beat updates the parser and ring registers and sets s1_valid_q;
//   the result beat is then registered into m_data_q once the output slot is free
// throughput: one beat per cycle while the output is not stalled; the ring memory takes one
//   write and two registered reads per cycle, all per-beat work sits in a single stage
// reset: rst_ni asynchronous active low clears pointers, fill count, parser
//   state, headers and config; ring memory contents are left unknown
module rx_packet_address_filter_fifo_core
  import rpaf_pkg::*;
#(
  parameter int FIFO_DEPTH = DEFAULT_FIFO_DEPTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [7:0]             s_axis_tdata,  // rx_byte
  input  logic                   s_axis_tlast,  // last_of_packet
  input  logic                   s_axis_tuser,  // operation
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // pop_byte, pop_valid, head_byte, head_valid, fill_count, header_source,
  // header_ident, header_flag_bits, packet_accepted, overflow, zero pad
  output logic [OUT_DATA_W-1:0]  m_axis_tdata,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [7:0]             cfg_data_i
);

  logic [7:0] node_q, bcast_q;
  logic       s1_valid_q, m_valid_q;
  logic [OUT_DATA_W-1:0] m_data_q;
  logic       accept, s1_adv, rx_beat, pop_beat, push;
  logic       accepted;
  hdr_t       hdr;
  ring_st_t   ring_st;

  assign cfg_ready_o   = 1'b1;
  assign s1_adv        = s1_valid_q && (!m_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign rx_beat       = (op_e'(s_axis_tuser) == OP_RX_BYTE);
  assign pop_beat      = (op_e'(s_axis_tuser) == OP_POP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_q  <= NODE_ADDR_RESET;
      bcast_q <= BCAST_ADDR_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_NODE_ADDR:  node_q  <= cfg_data_i;
        CFG_BCAST_ADDR: bcast_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  rpaf_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (accept),
    .rx_i        (rx_beat),
    .rx_byte_i   (s_axis_tdata),
    .last_i      (s_axis_tlast),
    .node_addr_i (node_q),
    .bcast_addr_i(bcast_q),
    .push_o      (push),
    .hdr_o       (hdr),
    .accepted_o  (accepted)
  );

  rpaf_ring #(
    .FIFO_DEPTH(FIFO_DEPTH)
  ) u_ring (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (accept),
    .pop_i (pop_beat),
    .push_i(push),
    .data_i(s_axis_tdata),
    .st_o  (ring_st)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      m_data_q <= {4'b0000,
                   ring_st.overflow,
                   accepted,
                   hdr.flags,
                   hdr.ident,
                   hdr.src,
                   ring_st.fill,
                   ring_st.head_valid,
                   ring_st.head_byte,
                   ring_st.pop_valid,
                   ring_st.pop_byte};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

>>> sv/rpaf_parser.sv
module rpaf_parser
  import rpaf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       rx_i,
  input  logic [7:0] rx_byte_i,
  input  logic       last_i,
  input  logic [7:0] node_addr_i,
  input  logic [7:0] bcast_addr_i,
  output logic       push_o,
  output hdr_t       hdr_o,
  output logic       accepted_o
);

  logic [7:0] pos_q, pos_d;
  logic       match_q, match_d;
  logic [7:0] pend_q [3];
  logic [7:0] pend_d [3];
  hdr_t       hdr_q, hdr_d;
  logic       acc_q, acc_d;
  logic [1:0] pend_idx;

  assign pend_idx = 2'(pos_q - 8'd1);

  always_comb begin
    pos_d   = pos_q;
    match_d = match_q;
    pend_d  = pend_q;
    hdr_d   = hdr_q;
    acc_d   = acc_q;
    push_o  = 1'b0;
    if (en_i) begin
      acc_d = 1'b0;
      if (rx_i) begin
        if (pos_q == 8'd0) begin
          match_d = (rx_byte_i == node_addr_i) || (rx_byte_i == bcast_addr_i);
        end else if (pos_q < 8'(HEADER_BYTES)) begin
          pend_d[pend_idx] = rx_byte_i;
        end else begin
          push_o = match_q;
        end
        if (last_i) begin
          if (pos_q >= 8'(HEADER_BYTES - 1)) begin
            hdr_d.src   = pend_d[0];
            hdr_d.ident = pend_d[1];
            hdr_d.flags = pend_d[2];
            acc_d       = match_d;
          end
          pos_d   = 8'd0;
          match_d = 1'b0;
        end else if (pos_q != 8'hFF) begin
          pos_d = pos_q + 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      match_q <= 1'b0;
      pend_q  <= '{default: '0};
      hdr_q   <= '0;
      acc_q   <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      match_q <= match_d;
      pend_q  <= pend_d;
      hdr_q   <= hdr_d;
      acc_q   <= acc_d;
    end
  end

  assign hdr_o      = hdr_q;
  assign accepted_o = acc_q;

endmodule

>>> sv/rpaf_ring.sv
module rpaf_ring
  import rpaf_pkg::*;
#(
  parameter int FIFO_DEPTH = DEFAULT_FIFO_DEPTH
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     pop_i,
  input  logic     push_i,
  input  logic [7:0] data_i,
  output ring_st_t st_o
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

  logic [7:0]       mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wp_q, wp_d, rp_q, rp_d, held_q, held_d;
  logic             popv_q, popv_d, ovf_q, ovf_d;
  logic [7:0]       pop_rd_q, head_rd_q;
  logic             full, do_push, do_pop;
  logic [PTR_W+7:0] held_wide;

  assign full    = (held_q == PTR_LAST);
  assign do_push = en_i && push_i && !full;
  assign do_pop  = en_i && pop_i && (held_q != '0);

  always_comb begin
    wp_d   = wp_q;
    rp_d   = rp_q;
    held_d = held_q;
    popv_d = popv_q;
    ovf_d  = ovf_q;
    if (en_i) begin
      popv_d = do_pop;
      ovf_d  = push_i && full;
    end
    if (do_push) begin
      wp_d   = (wp_q == PTR_LAST) ? '0 : wp_q + PTR_W'(1);
      held_d = held_q + PTR_W'(1);
    end
    if (do_pop) begin
      rp_d   = (rp_q == PTR_LAST) ? '0 : rp_q + PTR_W'(1);
      held_d = held_q - PTR_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      rp_q   <= '0;
      held_q <= '0;
      popv_q <= 1'b0;
      ovf_q  <= 1'b0;
    end else begin
      wp_q   <= wp_d;
      rp_q   <= rp_d;
      held_q <= held_d;
      popv_q <= popv_d;
      ovf_q  <= ovf_d;
    end
  end

  // write-first bypass when the pushed byte becomes the new head
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wp_q] <= data_i;
    end
    if (en_i) begin
      pop_rd_q  <= mem[rp_q];
      head_rd_q <= (do_push && (wp_q == rp_d)) ? data_i : mem[rp_d];
    end
  end

  assign held_wide = (PTR_W+8)'(held_q);

  always_comb begin
    st_o.pop_valid  = popv_q;
    st_o.overflow   = ovf_q;
    st_o.head_valid = (held_q != '0);
    st_o.fill       = (held_wide > (PTR_W+8)'(8'hFF)) ? 8'hFF : held_wide[7:0];
    st_o.pop_byte   = popv_q ? pop_rd_q : 8'h00;
    st_o.head_byte  = (held_q != '0) ? head_rd_q : 8'h00;
  end

endmodule

>>> dv/rx_packet_address_filter_fifo_core_test.sv
`timescale 1ns / 1ps
module rx_packet_address_filter_fifo_core_test;
  import rpaf_pkg::*;

  localparam int DEPTH = DEFAULT_FIFO_DEPTH;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED = CFG_INDEX_W'(2);
  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int HOLD_OFF_AFTER = 100;

  typedef struct {
    op_e        op;
    logic [7:0] data;
    logic       last;
  } rx_beat_t;

  typedef struct packed {
    logic [3:0] pad;
    logic       overflow;
    logic       accepted;
    logic [7:0] flags;
    logic [7:0] ident;
    logic [7:0] src;
    logic [7:0] fill;
    logic       head_valid;
    logic [7:0] head_byte;
    logic       pop_valid;
    logic [7:0] pop_byte;
  } filter_out_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [7:0]             s_axis_tdata = '0;
  logic                   s_axis_tlast = 1'b0;
  logic                   s_axis_tuser = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  m_axis_tdata;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_INDEX_W-1:0] cfg_index_i = '0;
  logic [7:0]             cfg_data_i = '0;

  rx_packet_address_filter_fifo_core #(
    .FIFO_DEPTH(DEPTH)
  ) u_top (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tlast,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  always #4 clk_i = ~clk_i;

  // filter and ring state as the block should hold it
  logic [7:0] ring_mem [DEPTH];
  int         wr_ptr = 0;
  int         rd_ptr = 0;
  int         stored = 0;
  int         hdr_pos = 0;
  logic       dest_hit = 1'b0;
  logic [7:0] hdr_pending [3] = '{default: 8'h00};
  logic [7:0] hdr_latched [3] = '{default: 8'h00};
  logic [7:0] my_addr = NODE_ADDR_RESET;
  logic [7:0] bcast_addr = BCAST_ADDR_RESET;

  rx_beat_t    pending_beats [$];
  filter_out_t expected_results [$];
  int          errors = 0;
  int          rx_accepted = 0;
  int          beats_queued = 0;

  function automatic filter_out_t filter_step(rx_beat_t b);
    filter_out_t r;
    r = '0;
    if (b.op == OP_POP) begin
      if (stored > 0) begin
        r.pop_byte = ring_mem[rd_ptr];
        r.pop_valid = 1'b1;
        rd_ptr = (rd_ptr + 1) % DEPTH;
        stored--;
      end
    end else begin
      if (hdr_pos == 0) begin
        dest_hit = (b.data == my_addr) || (b.data == bcast_addr);
      end else if (hdr_pos < HEADER_BYTES) begin
        hdr_pending[hdr_pos - 1] = b.data;
      end else if (dest_hit) begin
        if (stored < DEPTH - 1) begin
          ring_mem[wr_ptr] = b.data;
          wr_ptr = (wr_ptr + 1) % DEPTH;
          stored++;
        end else begin
          r.overflow = 1'b1;
        end
      end
      if (b.last) begin
        if (hdr_pos + 1 >= HEADER_BYTES) begin
          hdr_latched = hdr_pending;
          r.accepted = dest_hit;
        end
        hdr_pos = 0;
        dest_hit = 1'b0;
      end else if (hdr_pos < 255) begin
        hdr_pos++;
      end
    end
    if (stored > 0) begin
      r.head_valid = 1'b1;
      r.head_byte = ring_mem[rd_ptr];
    end
    r.fill = (stored > 255) ? 8'd255 : 8'(stored);
    r.src = hdr_latched[0];
    r.ident = hdr_latched[1];
    r.flags = hdr_latched[2];
    return r;
  endfunction

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t %s mismatch: expected %h, got %h", $time, name, want, got);
      errors++;
    end
  endtask

  // sender: bursts of random length with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni && !(s_axis_tvalid && !s_axis_tready)) begin
      if (s_axis_tvalid) begin
        void'(pending_beats.pop_front());
      end
      if (gap_left > 0) begin
        s_axis_tvalid <= 1'b0;
        gap_left--;
      end else if (pending_beats.size() > 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pending_beats[0].data;
        s_axis_tlast <= pending_beats[0].last;
        s_axis_tuser <= pending_beats[0].op;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern that changes at random intervals, plus one long hold-off
  int  stall_mode = 0;
  int  mode_left = 0;
  int  hold_left = 0;
  bit  held_off = 1'b0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!held_off && rx_accepted >= HOLD_OFF_AFTER) begin
        held_off = 1'b1;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 96);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (stall_mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= 1'($urandom_range(0, 1));
          2: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // predict on every accepted input beat, track register writes
  always @(posedge clk_i) begin : predict
    rx_beat_t b;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      b.op = op_e'(s_axis_tuser);
      b.data = s_axis_tdata;
      b.last = s_axis_tlast;
      expected_results.push_back(filter_step(b));
      rx_accepted++;
    end
    if (rst_ni && cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_NODE_ADDR: my_addr = cfg_data_i;
        CFG_BCAST_ADDR: bcast_addr = cfg_data_i;
        default: ;
      endcase
    end
  end

  always @(posedge clk_i) begin : result_check
    filter_out_t got;
    filter_out_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (expected_results.size() == 0) begin
        $display("%0t unexpected result beat: expected none, got %h", $time, m_axis_tdata);
        errors++;
      end else begin
        want = expected_results.pop_front();
        check_field("pop_byte", want.pop_byte, got.pop_byte);
        check_field("pop_valid", 8'(want.pop_valid), 8'(got.pop_valid));
        check_field("head_byte", want.head_byte, got.head_byte);
        check_field("head_valid", 8'(want.head_valid), 8'(got.head_valid));
        check_field("fill_count", want.fill, got.fill);
        check_field("header_source", want.src, got.src);
        check_field("header_ident", want.ident, got.ident);
        check_field("header_flag_bits", want.flags, got.flags);
        check_field("packet_accepted", 8'(want.accepted), 8'(got.accepted));
        check_field("overflow", 8'(want.overflow), 8'(got.overflow));
      end
    end
  end

  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t no beat accepted for %0d cycles", $time, IDLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic add_beat(op_e op, logic [7:0] data, logic last);
    rx_beat_t b;
    b.op = op;
    b.data = data;
    b.last = last;
    pending_beats.push_back(b);
    beats_queued++;
  endtask

  // pop beats carry random byte and last, both must be ignored
  task automatic add_pop();
    add_beat(OP_POP, 8'($urandom), 1'($urandom_range(0, 1)));
  endtask

  task automatic add_packet(logic [7:0] dest, int len, int pop_pct);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < pop_pct) begin
        add_pop();
      end
      add_beat(OP_RX_BYTE, (i == 0) ? dest : 8'($urandom), i == len - 1);
    end
  endtask

  task automatic run_mix(int beats, int pop_pct);
    int start;
    int pick;
    int len;
    logic [7:0] dest;
    start = beats_queued;
    while (beats_queued - start < beats) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        add_beat(OP_RX_BYTE, 8'($urandom), 1'($urandom_range(0, 1)));
      end else if (pick < 10) begin
        add_pop();
      end else begin
        pick = $urandom_range(0, 99);
        dest = (pick < 40) ? my_addr : (pick < 65) ? bcast_addr : 8'($urandom);
        pick = $urandom_range(0, 99);
        len = (pick < 20) ? $urandom_range(1, 3) :
              (pick < 95) ? $urandom_range(4, 14) : $urandom_range(20, 40);
        add_packet(dest, len, pop_pct);
      end
    end
  endtask

  task automatic wait_idle();
    while (pending_beats.size() != 0 || expected_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic put_reg(logic [CFG_INDEX_W-1:0] index, logic [7:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic configure(logic [7:0] node, logic [7:0] bcast, bit poke_unmapped);
    put_reg(CFG_NODE_ADDR, node);
    put_reg(CFG_BCAST_ADDR, bcast);
    if (poke_unmapped) begin
      put_reg(CFG_UNMAPPED, 8'($urandom));
    end
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset addresses: node 00, broadcast ff
    add_pop();
    add_packet(8'hFF, 2, 0);
    add_packet(8'h00, 1, 0);
    add_beat(OP_RX_BYTE, 8'h00, 1'b0);
    add_beat(OP_RX_BYTE, 8'hFF, 1'b0);
    add_beat(OP_RX_BYTE, 8'h00, 1'b0);
    add_beat(OP_RX_BYTE, 8'hA5, 1'b0);
    add_beat(OP_RX_BYTE, 8'h00, 1'b0);
    add_pop();
    add_beat(OP_RX_BYTE, 8'hFF, 1'b0);
    add_beat(OP_RX_BYTE, 8'h5A, 1'b1);
    add_packet(8'h37, 6, 0);
    add_packet(8'hFF, 4, 0);
    repeat (4) add_pop();
    // packet left open across the register write, its match stays latched
    add_beat(OP_RX_BYTE, 8'h5A, 1'b0);
    add_beat(OP_RX_BYTE, 8'h11, 1'b0);
    wait_idle();

    configure(8'h5A, 8'hFF, 1'b1);
    add_beat(OP_RX_BYTE, 8'h22, 1'b0);
    add_beat(OP_RX_BYTE, 8'h33, 1'b0);
    add_beat(OP_RX_BYTE, 8'h44, 1'b0);
    add_beat(OP_RX_BYTE, 8'h55, 1'b1);
    // long packet: position saturates and the ring overflows
    add_packet(8'h5A, 280, 0);
    run_mix(120, 70);
    wait_idle();

    configure(8'hFF, 8'h00, 1'b1);
    run_mix(70, 25);
    wait_idle();

    configure(8'h00, 8'h00, 1'b0);
    run_mix(70, 30);
    wait_idle();

    configure(8'($urandom), 8'($urandom), 1'b1);
    run_mix(70, 20);
    wait_idle();

    configure(8'hFF, 8'hFF, 1'b0);
    run_mix(70, 40);
    wait_idle();

    repeat (10) @(posedge clk_i);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/rpaf_pkg.sv
sv/rpaf_parser.sv
sv/rpaf_ring.sv
sv/rx_packet_address_filter_fifo_core.sv
dv/rx_packet_address_filter_fifo_core_test.sv
